### rtl/core/smxr_pkg.sv
// Shared types, constants and helper functions for the S-box multiply-xor round.
// Used by the lane datapath, the top level and the port checker; depends on nothing.
`default_nettype none

package smxr_pkg;

    // Fixed field widths of the stream payload.
    localparam int WORD_W       = 64;
    localparam int HALF_W       = 32;
    localparam int ENTRY_W      = 2 * WORD_W;
    localparam int FIELD_IDX_W  = 8;
    localparam int MASK_W       = 8;
    localparam int ACTION_W     = 2;
    localparam int NUM_WORDS    = 8;
    localparam int MAX_LANES    = NUM_WORDS / 2;
    localparam int OFFSET_SHIFT = 4;
    localparam int S_TDATA_W    = FIELD_IDX_W + NUM_WORDS * WORD_W;
    localparam int M_TDATA_W    = NUM_WORDS * WORD_W;

    // Width used while reducing an 8-bit index modulo the store depth (up to 4096).
    localparam int RED_W = 13;

    // Reciprocal of the store depth, scaled by 2^RECIP_SHIFT and rounded up. For an
    // 8-bit index and a depth of 16 to 4096 the index times the rounding error stays
    // below 2^RECIP_SHIFT, so the quotient taken from it is exact.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 17;
    localparam int SCALED_W    = FIELD_IDX_W + RECIP_W;
    localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;
    localparam int BACK_W      = QUOT_W + RED_W;

    localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

    // Kinds of input transaction, carried on s_tuser.
    typedef enum logic [ACTION_W-1:0] {
        ACT_TRANSFORM    = 2'd0,
        ACT_WRITE_FIRST  = 2'd1,
        ACT_WRITE_SECOND = 2'd2
    } action_t;

    // Per-transaction strobes from the top level to every lane.
    typedef struct packed {
        logic rd_en;
        logic wr_first;
        logic wr_second;
    } lane_ctrl_t;

    // Remainder of an 8-bit value by the store depth: one small multiplication by the
    // reciprocal gives the quotient, one multiply-back and subtract gives the remainder.
    function automatic logic [RED_W-1:0] reduce_index(input logic [FIELD_IDX_W-1:0] v,
                                                      input logic [RED_W-1:0] n,
                                                      input logic [RECIP_W-1:0] recip);
        logic [SCALED_W-1:0] scaled;
        logic [QUOT_W-1:0]   quot;
        logic [BACK_W-1:0]   back;
        scaled = SCALED_W'(v) * SCALED_W'(recip);
        quot   = scaled[SCALED_W-1:RECIP_SHIFT];
        back   = BACK_W'(quot) * BACK_W'(n);
        return RED_W'(v) - back[RED_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/smxr_lane.sv
// One lane of the round: private copies of both S-boxes, entry lookup,
// two 32x32 multipliers and the add-xor mix. Depends on smxr_pkg.
`default_nettype none

module smxr_lane #(
    parameter int SBOX_ENTRIES = 256
) (
    input  wire logic                                     aclk,
    input  wire smxr_pkg::lane_ctrl_t                     ctrl,
    input  wire logic [$clog2(SBOX_ENTRIES)-1:0]          wr_index,
    input  wire logic [smxr_pkg::ENTRY_W-1:0]             wr_entry,
    input  wire logic [smxr_pkg::MASK_W-1:0]              entry_mask,
    input  wire logic [smxr_pkg::WORD_W-1:0]              word_a,
    input  wire logic [smxr_pkg::WORD_W-1:0]              word_b,
    output logic      [smxr_pkg::WORD_W-1:0]              res_a,
    output logic      [smxr_pkg::WORD_W-1:0]              res_b
);

    localparam int IDX_W = $clog2(SBOX_ENTRIES);
    localparam logic [smxr_pkg::RED_W-1:0] ENTRIES_N = SBOX_ENTRIES[smxr_pkg::RED_W-1:0];
    localparam int ENTRIES_RECIP_I =
        ((1 << smxr_pkg::RECIP_SHIFT) + SBOX_ENTRIES - 1) / SBOX_ENTRIES;
    localparam logic [smxr_pkg::RECIP_W-1:0] ENTRIES_RECIP =
        ENTRIES_RECIP_I[smxr_pkg::RECIP_W-1:0];

    localparam int W  = smxr_pkg::WORD_W;
    localparam int H  = smxr_pkg::HALF_W;
    localparam int SH = smxr_pkg::OFFSET_SHIFT;
    localparam int MW = smxr_pkg::MASK_W;

    logic [smxr_pkg::ENTRY_W-1:0] first_mem  [SBOX_ENTRIES];
    logic [smxr_pkg::ENTRY_W-1:0] second_mem [SBOX_ENTRIES];

    logic [smxr_pkg::ENTRY_W-1:0] first_rd_reg;
    logic [smxr_pkg::ENTRY_W-1:0] second_rd_reg;
    logic [W-1:0]                 prod_a_reg;
    logic [W-1:0]                 prod_b_reg;
    logic [W-1:0]                 prod_a_next;
    logic [W-1:0]                 prod_b_next;

    logic [MW-1:0]                first_sel;
    logic [MW-1:0]                second_sel;
    logic [smxr_pkg::RED_W-1:0]   first_red;
    logic [smxr_pkg::RED_W-1:0]   second_red;
    logic [IDX_W-1:0]             first_idx;
    logic [IDX_W-1:0]             second_idx;

    // The low and high byte offsets of the first word, in 16-byte entries, masked.
    assign first_sel  = word_a[SH +: MW] & entry_mask;
    assign second_sel = word_a[H + SH +: MW] & entry_mask;
    assign first_red  = smxr_pkg::reduce_index(first_sel, ENTRIES_N, ENTRIES_RECIP);
    assign second_red = smxr_pkg::reduce_index(second_sel, ENTRIES_N, ENTRIES_RECIP);
    assign first_idx  = first_red[IDX_W-1:0];
    assign second_idx = second_red[IDX_W-1:0];

    // High half times low half of each word.
    assign prod_a_next = word_a[W-1:H] * word_a[H-1:0];
    assign prod_b_next = word_b[W-1:H] * word_b[H-1:0];

    // First S-box copy: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_first) begin
            first_mem[wr_index] <= wr_entry;
        end
        if (ctrl.rd_en) begin
            first_rd_reg <= first_mem[first_idx];
        end
    end

    // Second S-box copy.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_second) begin
            second_mem[wr_index] <= wr_entry;
        end
        if (ctrl.rd_en) begin
            second_rd_reg <= second_mem[second_idx];
        end
    end

    // Products are registered alongside the lookups.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // Add the first-box half, then flip with the second-box half, modulo 2^64.
    assign res_a = (prod_a_reg + first_rd_reg[W-1:0]) ^ second_rd_reg[W-1:0];
    assign res_b = (prod_b_reg + first_rd_reg[2*W-1:W]) ^ second_rd_reg[2*W-1:W];

endmodule

`default_nettype wire

### rtl/core/sbox_multiply_xor_round.sv
// Top level of the S-box multiply-xor round: stream handshake, mask register,
// lane array and result register. Depends on smxr_pkg and smxr_lane.
//
// Usage:
//   The s_ channel takes one transaction per beat. s_tuser gives its kind:
//   transform, write first S-box entry or write second S-box entry. A write
//   stores {word_1, word_0} at entry_index in every lane's copy of that box
//   and gives no result. A transform gives one m_ transaction with the eight
//   words, mixed in each lane that is built. Code 3 on s_tuser is dropped without effect.
//   cfg_wr_en/cfg_wr_data load the entry mask; write it only while idle.
//   A transform is held in the lookup and multiply registers, then in the
//   result register, from which it shows on m_tvalid.
//   Throughput: one transaction per cycle unless m_tready stalls it, set by
//   the registered S-box read port and the multiplier register in each lane.
//   A write may be followed in the next cycle by a transform that reads it.
//   Reset clears the pipeline valids and sets the mask to all ones; the
//   S-box contents are not cleared and hold nothing until written.
//   When m_tready is low the result holds and one further transform waits in
//   the lookup register; s_tready falls only when both are occupied.
`default_nettype none

module sbox_multiply_xor_round #(
    parameter int SBOX_ENTRIES = 256,
    parameter int LANES        = 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [smxr_pkg::MASK_W-1:0]        cfg_wr_data,   // entry_mask

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // entry_index[7:0], word_0[71:8], word_1 .. word_7 up to bit 519
    input  wire logic [smxr_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[1:0]
    input  wire logic [smxr_pkg::ACTION_W-1:0]      s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_0[63:0], out_1[127:64] .. out_7[511:448]
    output logic      [smxr_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int IDX_W      = $clog2(SBOX_ENTRIES);
    localparam int LANES_USED = (LANES < smxr_pkg::MAX_LANES) ? LANES : smxr_pkg::MAX_LANES;
    localparam logic [smxr_pkg::RED_W-1:0] ENTRIES_N = SBOX_ENTRIES[smxr_pkg::RED_W-1:0];
    localparam int ENTRIES_RECIP_I =
        ((1 << smxr_pkg::RECIP_SHIFT) + SBOX_ENTRIES - 1) / SBOX_ENTRIES;
    localparam logic [smxr_pkg::RECIP_W-1:0] ENTRIES_RECIP =
        ENTRIES_RECIP_I[smxr_pkg::RECIP_W-1:0];

    localparam int W  = smxr_pkg::WORD_W;
    localparam int FW = smxr_pkg::FIELD_IDX_W;

    logic [smxr_pkg::MASK_W-1:0]    entry_mask_reg;
    logic                           stg_valid_reg;
    logic                           stg_valid_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [smxr_pkg::M_TDATA_W-1:0] m_data_reg;

    logic                           s_accept;
    logic                           out_ready;
    logic                           out_load;
    smxr_pkg::lane_ctrl_t           lane_ctrl;
    logic [smxr_pkg::RED_W-1:0]     wr_red;
    logic [IDX_W-1:0]               wr_index;
    logic [smxr_pkg::ENTRY_W-1:0]   wr_entry;
    logic [smxr_pkg::M_TDATA_W-1:0] res_data;

    // Handshake: the lookup stage frees up whenever the result register can move.
    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !stg_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign out_load  = out_ready && stg_valid_reg;

    // Decode the transaction kind into lane strobes.
    always_comb begin
        lane_ctrl = '0;
        case (smxr_pkg::action_t'(s_tuser))
            smxr_pkg::ACT_TRANSFORM:    lane_ctrl.rd_en     = s_accept;
            smxr_pkg::ACT_WRITE_FIRST:  lane_ctrl.wr_first  = s_accept;
            smxr_pkg::ACT_WRITE_SECOND: lane_ctrl.wr_second = s_accept;
            default:                    lane_ctrl = '0;
        endcase
    end

    // Write address and data shared by every lane copy.
    assign wr_red   = smxr_pkg::reduce_index(s_tdata[FW-1:0], ENTRIES_N, ENTRIES_RECIP);
    assign wr_index = wr_red[IDX_W-1:0];
    assign wr_entry = s_tdata[FW +: smxr_pkg::ENTRY_W];

    // Lanes that are built do the lookups; any others pass their words through.
    for (genvar l = 0; l < smxr_pkg::MAX_LANES; l++) begin : g_lane
        if (l < LANES_USED) begin : g_active
            smxr_lane #(
                .SBOX_ENTRIES (SBOX_ENTRIES)
            ) u_lane (
                .aclk       (aclk),
                .ctrl       (lane_ctrl),
                .wr_index   (wr_index),
                .wr_entry   (wr_entry),
                .entry_mask (entry_mask_reg),
                .word_a     (s_tdata[FW + 2*l*W +: W]),
                .word_b     (s_tdata[FW + (2*l+1)*W +: W]),
                .res_a      (res_data[2*l*W +: W]),
                .res_b      (res_data[(2*l+1)*W +: W])
            );
        end else begin : g_pass
            logic [2*W-1:0] pass_reg;

            always_ff @(posedge aclk) begin
                if (lane_ctrl.rd_en) begin
                    pass_reg <= s_tdata[FW + 2*l*W +: 2*W];
                end
            end

            assign res_data[2*l*W +: 2*W] = pass_reg;
        end
    end

    // Valid flags of the lookup stage and the result register.
    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_tready) begin
            stg_valid_next = lane_ctrl.rd_en;
        end
        m_valid_next = m_valid_reg;
        if (out_ready) begin
            m_valid_next = stg_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            entry_mask_reg <= smxr_pkg::MASK_RESET;
        end else begin
            stg_valid_reg <= stg_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                entry_mask_reg <= cfg_wr_data;
            end
        end
    end

    // Result register, loaded when the lookup stage hands over.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

### rtl/core/smxr_checker.sv
// Port-level checks for sbox_multiply_xor_round, bound to the top level.
// Depends on smxr_pkg.
`default_nettype none

module smxr_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [smxr_pkg::ACTION_W-1:0]  s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [smxr_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("result valid after reset");

    // A new result always follows an accepted transform, through the lookup stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && s_tuser == smxr_pkg::ACT_TRANSFORM, 2))
    else $error("result without a transform");

    // Input back-pressure only while the output is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output free");

endmodule

bind sbox_multiply_xor_round smxr_checker u_smxr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the S-box multiply-xor round (sbox_multiply_xor_round).
// A directed table, a fill of both boxes and random traffic are checked against
// literal rows or an in-bench predictor. Depends on smxr_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int ACTION_W     = smxr_pkg::ACTION_W;
    localparam int FIELD_IDX_W  = smxr_pkg::FIELD_IDX_W;
    localparam int WORD_W       = smxr_pkg::WORD_W;
    localparam int HALF_W       = smxr_pkg::HALF_W;
    localparam int NUM_WORDS    = smxr_pkg::NUM_WORDS;
    localparam int MAX_LANES    = smxr_pkg::MAX_LANES;
    localparam int MASK_W       = smxr_pkg::MASK_W;
    localparam int OFFSET_SHIFT = smxr_pkg::OFFSET_SHIFT;
    localparam int S_TDATA_W    = smxr_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = smxr_pkg::M_TDATA_W;

    localparam int SBOX_ENTRIES   = 256;
    localparam int LANES          = 4;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DIR_ROWS       = 17;

    // Code 3 on s_tuser has no member in the package enum; the block drops it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;

    localparam word_t ZERO = '0;
    localparam word_t ONES = '1;

    // One directed transaction: word_a and word_b go to words 0 and 1, word_rest fills
    // words 2 to 7. A literal expectation repeats lit_even/lit_odd across the lanes.
    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [FIELD_IDX_W-1:0] entry;
        word_t                  word_a;
        word_t                  word_b;
        word_t                  word_rest;
        logic                   has_lit;
        word_t                  lit_even;
        word_t                  lit_odd;
    } dir_row_t;

    dir_row_t dir_table [DIR_ROWS] = '{
        // Seed entries 0 and 255 of both boxes before anything reads them.
        '{smxr_pkg::ACT_WRITE_FIRST,  8'h00, 64'd1, 64'd2, ZERO, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_WRITE_SECOND, 8'h00, ZERO, ZERO, ONES, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_WRITE_FIRST,  8'hFF, ZERO, ZERO, ZERO, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_WRITE_SECOND, 8'hFF, ONES, ONES, ONES, 1'b0, ZERO, ZERO},
        // All-zero words: no product, entry 0 of each box.
        '{smxr_pkg::ACT_TRANSFORM,    8'hFF, ZERO, ZERO, ZERO, 1'b1, 64'd1, 64'd2},
        // All-ones words: largest product, entry 255 of each box.
        '{smxr_pkg::ACT_TRANSFORM,    8'h00, ONES, ONES, ONES, 1'b1,
          64'h0000_0001_FFFF_FFFE, 64'h0000_0001_FFFF_FFFE},
        // Unused action code must leave no trace.
        '{ACT_UNUSED,                 8'h5A, ONES, ONES, ONES, 1'b0, ZERO, ZERO},
        // Unaligned offsets: the low four bits are dropped, so entry 0 is read.
        '{smxr_pkg::ACT_TRANSFORM, 8'h00, 64'h0000_000F_0000_000F, 64'h0000_000F_0000_000F,
          64'h0000_000F_0000_000F, 1'b1, 64'd226, 64'd227},
        '{smxr_pkg::ACT_WRITE_FIRST, 8'hAA, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
          ONES, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_WRITE_SECOND, 8'h55, 64'hA5A5_A5A5_5A5A_5A5A, 64'h0F0F_0F0F_F0F0_F0F0,
          ZERO, 1'b0, ZERO, ZERO},
        // Distinct entries per box; lane 0 reads other entries than lanes 1 to 3.
        '{smxr_pkg::ACT_TRANSFORM,    8'h33, 64'h0000_0550_0000_0AA0, ONES,
          64'hFFFF_FFF0_0000_0000, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_TRANSFORM,    8'hCC, 64'h0000_055F_0000_0AAF, ZERO,
          64'h0000_0550_0000_0AA0, 1'b0, ZERO, ZERO},
        // Overwrite an entry and read it straight away; the sum wraps.
        '{smxr_pkg::ACT_WRITE_FIRST, 8'hFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
          ZERO, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_TRANSFORM,    8'h00, ONES, ZERO, ONES, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_WRITE_SECOND, 8'h00, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
          ONES, 1'b0, ZERO, ZERO},
        '{smxr_pkg::ACT_TRANSFORM, 8'hFF, 64'hFFFF_FFF0_0000_0000, 64'h1234_5678_9ABC_DEF0,
          64'h0000_000F_FFFF_FFF0, 1'b0, ZERO, ZERO},
        '{ACT_UNUSED,                 8'h00, ZERO, ZERO, ZERO, 1'b0, ZERO, ZERO}
    };

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en;
    logic [MASK_W-1:0]      cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;      // entry_index, word_0 .. word_7
    logic [ACTION_W-1:0]    s_tuser;      // action
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;      // out_0 .. out_7

    // Predictor state: both boxes as {low half, high half} and the entry mask.
    word_t              first_box  [SBOX_ENTRIES][2];
    word_t              second_box [SBOX_ENTRIES][2];
    logic [MASK_W-1:0]  mask_model = smxr_pkg::MASK_RESET;
    block_t             expected_blocks [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int results_seen = 0;
    int n_transforms = 0;
    int n_writes = 0;
    int n_ignored = 0;
    int masks_written = 0;

    sbox_multiply_xor_round #(
        .SBOX_ENTRIES (SBOX_ENTRIES),
        .LANES        (LANES)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock with a 4 ns period.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mixes one block of eight words through the current boxes and mask.
    function automatic block_t mix_block(input block_t w);
        block_t r;
        logic [HALF_W-1:0] off_a;
        logic [HALF_W-1:0] off_b;
        int ia;
        int ib;
        word_t prod;
        r = w;
        for (int ln = 0; ln < LANES && ln < MAX_LANES; ln++) begin
            off_a = (w[2*ln][HALF_W-1:0] >> OFFSET_SHIFT) & HALF_W'(mask_model);
            off_b = (w[2*ln][WORD_W-1:HALF_W] >> OFFSET_SHIFT) & HALF_W'(mask_model);
            ia = off_a % SBOX_ENTRIES;
            ib = off_b % SBOX_ENTRIES;
            for (int j = 0; j < 2; j++) begin
                prod = word_t'(w[2*ln+j][WORD_W-1:HALF_W]) * word_t'(w[2*ln+j][HALF_W-1:0]);
                r[2*ln+j] = (prod + first_box[ia][j]) ^ second_box[ib][j];
            end
        end
        return r;
    endfunction

    // Random word, biased now and then towards the two extremes.
    function automatic word_t rand_word();
        case ($urandom_range(9))
            0: begin
                rand_word = ZERO;
            end
            1: begin
                rand_word = ONES;
            end
            default: begin
                rand_word = {$urandom, $urandom};
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int word_no,
                                   input word_t got, input word_t want);
        error_count++;
        $display("MISMATCH at %0t: %s, word %0d: got %h, expected %h",
                 $time, what, word_no, got, want);
    endtask

    // Drives one input transaction, waits for its acceptance and updates the predictor.
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [FIELD_IDX_W-1:0] idx,
                             input block_t words, input logic has_lit, input block_t lit);
        int slot;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {words, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        slot = idx % SBOX_ENTRIES;
        case (act)
            smxr_pkg::ACT_WRITE_FIRST: begin
                first_box[slot][0] = words[0];
                first_box[slot][1] = words[1];
                n_writes++;
            end
            smxr_pkg::ACT_WRITE_SECOND: begin
                second_box[slot][0] = words[0];
                second_box[slot][1] = words[1];
                n_writes++;
            end
            smxr_pkg::ACT_TRANSFORM: begin
                expected_blocks.push_back(has_lit ? lit : mix_block(words));
                n_transforms++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_blocks.size() != 0) @(posedge aclk);
    endtask

    // Loads the entry mask once the block has gone quiet.
    task automatic write_mask(input logic [MASK_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mask_model = value;
        masks_written++;
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each result transaction is compared with the oldest expectation.
    always @(posedge aclk) begin : result_check
        block_t got;
        block_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with nothing expected", 0, got[0], ZERO);
            end else begin
                want = expected_blocks.pop_front();
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (got[k] !== want[k]) begin
                        report_mismatch("output word differs", k, got[k], want[k]);
                    end
                end
            end
        end
    end

    // Ends the run if no transaction is accepted on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        block_t w;
        block_t lit;
        logic [ACTION_W-1:0] act;
        logic [MASK_W-1:0] mask_value;
        int pick;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = smxr_pkg::ACT_TRANSFORM;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table at the reset mask, no idling.
        foreach (dir_table[i]) begin
            w   = {{6{dir_table[i].word_rest}}, dir_table[i].word_b, dir_table[i].word_a};
            lit = {4{dir_table[i].lit_odd, dir_table[i].lit_even}};
            send_item(dir_table[i].action, dir_table[i].entry, w, dir_table[i].has_lit, lit);
        end

        // Fill every entry of both boxes so that no random transform reads a blank one.
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        for (int e = 0; e < SBOX_ENTRIES; e++) begin
            for (int k = 0; k < NUM_WORDS; k++) w[k] = {$urandom, $urandom};
            send_item(smxr_pkg::ACT_WRITE_FIRST, FIELD_IDX_W'(e), w, 1'b0, '0);
            for (int k = 0; k < NUM_WORDS; k++) w[k] = {$urandom, $urandom};
            send_item(smxr_pkg::ACT_WRITE_SECOND, FIELD_IDX_W'(e), w, 1'b0, '0);
        end

        // Random traffic over several mask settings and idling patterns.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            case (ph)
                0:       mask_value = 8'h00;
                1:       mask_value = 8'hFF;
                3:       mask_value = 8'h0F;
                4:       mask_value = 8'hF0;
                default: mask_value = MASK_W'($urandom_range(255));
            endcase
            write_mask(mask_value);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                pick = $urandom_range(99);
                for (int k = 0; k < NUM_WORDS; k++) w[k] = rand_word();
                if (pick < 70) begin
                    act = smxr_pkg::ACT_TRANSFORM;
                end else if (pick < 82) begin
                    act = smxr_pkg::ACT_WRITE_FIRST;
                end else if (pick < 94) begin
                    act = smxr_pkg::ACT_WRITE_SECOND;
                end else begin
                    act = ACT_UNUSED;
                end
                send_item(act, FIELD_IDX_W'($urandom_range(255)), w, 1'b0, '0);
            end
        end

        // Let the pipeline empty and settle before the summary.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run summary: %0d transforms, %0d S-box writes, %0d ignored codes sent;",
                 n_transforms, n_writes, n_ignored);
        $display("             %0d results checked over %0d mask loads, %0d mismatches.",
                 results_seen, masks_written, error_count);
        if (error_count == 0 && expected_blocks.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### sbox_multiply_xor_round.f
rtl/core/smxr_pkg.sv
rtl/core/smxr_lane.sv
rtl/core/sbox_multiply_xor_round.sv
rtl/core/smxr_checker.sv
tb/testbench.sv
